// File: rtl/apc_pkg.sv
// Shared constants and types for the anagram pair checker.
// No dependencies; imported by every module in rtl/.
package apc_pkg;

    localparam int MAX_WORD  = 4096;
    localparam int ALPHABET  = 256;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = $clog2(MAX_WORD + 1);
    localparam int CNT_W     = LEN_W + 1;
    localparam int IDX_W     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int NZ_W      = $clog2(ALPHABET + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    // One accepted request on its way to the histogram stage
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             minus;
        logic             counted;
        logic             last;
        logic             too_long;
    } apc_req_t;

    typedef struct packed {
        logic too_long;
        logic is_anagram;
    } apc_res_t;

endpackage

// File: rtl/anagram_pair_checker.sv
// Anagram pair checker: one character request per cycle while s_tready is high.
// The pair-end request is registered by apc_front; its verdict is then queued for m_tvalid.
// Throughput: one read-modify-write of the difference table per cycle; a back-to-back
// hit on the same entry is forwarded. Input stalls only when queued verdicts plus the one
// being decided fill the four-entry result queue.
// Reset (rst_n, async, active low) empties the table at once through per-entry live bits.
// Depends on apc_pkg, apc_front, apc_hist, apc_out_fifo.
module anagram_pair_checker
    import apc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] character
    input  logic       s_tuser,  // [0] second_word
    input  logic       s_tlast,  // pair_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [0] is_anagram, [1] too_long, [7:2] zero
);

    logic              accept;
    logic [IDX_W-1:0]  rd_idx;
    apc_req_t          req;
    logic              res_valid;
    apc_res_t          res;
    apc_res_t          out_res;
    logic [OCNT_W-1:0] out_count;
    logic [OCNT_W:0]   pending;

    // Results already queued plus the one being decided this cycle; a request
    // taken now is decided in the table stage and then queued, so keep a free slot for it.
    assign pending  = {1'b0, out_count} + (OCNT_W + 1)'(res_valid);
    assign s_tready = (pending < (OCNT_W + 1)'(OUT_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // Accept stage: index, word lengths, overflow flag; starts the table read
    apc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .character   (s_tdata[CHAR_W-1:0]),
        .second_word (s_tuser),
        .pair_end    (s_tlast),
        .rd_idx      (rd_idx),
        .req         (req)
    );

    // Table stage: read data back, update count, write, decide on pair end
    apc_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_idx    (rd_idx),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    apc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .pop_valid (m_tvalid),
        .pop_data  (out_res),
        .count     (out_count)
    );

    assign m_tdata = {6'b0, out_res.too_long, out_res.is_anagram};

endmodule

// File: rtl/apc_front.sv
// Accept stage: character index, word lengths and overflow tracking.
// Depends on apc_pkg.
module apc_front
    import apc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAR_W-1:0] character,
    input  logic              second_word,
    input  logic              pair_end,
    output logic [IDX_W-1:0]  rd_idx,
    output apc_req_t          req
);

    logic [LEN_W-1:0] first_len_reg;
    logic [LEN_W-1:0] second_len_reg;
    logic             overflow_reg;
    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             minus_reg;
    logic             counted_reg;
    logic             last_reg;
    logic             too_long_reg;

    logic [LEN_W-1:0] sel_len;
    logic             counted;
    logic             ov_next;

    always_comb
    begin
        if ({1'b0, character} < (CHAR_W + 1)'(ALPHABET))
            rd_idx = IDX_W'(character);
        else
            rd_idx = IDX_W'(ALPHABET - 1);
        sel_len = second_word ? second_len_reg : first_len_reg;
        counted = (sel_len < LEN_W'(MAX_WORD));
        ov_next = overflow_reg | ~counted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            overflow_reg   <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            if (accept)
            begin
                if (pair_end)
                begin
                    first_len_reg  <= '0;
                    second_len_reg <= '0;
                    overflow_reg   <= 1'b0;
                end
                else
                begin
                    overflow_reg <= ov_next;
                    if (counted && second_word)
                        second_len_reg <= second_len_reg + LEN_W'(1);
                    if (counted && !second_word)
                        first_len_reg <= first_len_reg + LEN_W'(1);
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= rd_idx;
            minus_reg    <= second_word;
            counted_reg  <= counted;
            last_reg     <= pair_end;
            too_long_reg <= ov_next;
        end
    end

    assign req = '{valid: valid_reg, idx: idx_reg, minus: minus_reg, counted: counted_reg,
                   last: last_reg, too_long: too_long_reg};

endmodule

// File: rtl/apc_hist.sv
// Difference table memory with read-modify-write, forwarding and nonzero count.
// Depends on apc_pkg.
module apc_hist
    import apc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  apc_req_t         req,
    output logic             res_valid,
    output apc_res_t         res
);

    logic [CNT_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] live_reg;
    logic [CNT_W-1:0]    rd_data_reg;
    logic                rd_live_reg;
    logic [NZ_W-1:0]     nz_reg;

    // write made at the same edge as the current request's read
    logic                fwd_wr_reg;
    logic                fwd_clr_reg;
    logic [IDX_W-1:0]    fwd_idx_reg;
    logic [CNT_W-1:0]    fwd_val_reg;

    logic [CNT_W-1:0] before_val;
    logic [CNT_W-1:0] after_val;
    logic [NZ_W-1:0]  nz_upd;
    logic             do_write;

    always_comb
    begin
        if (fwd_clr_reg)
            before_val = '0;
        else if (fwd_wr_reg && (fwd_idx_reg == req.idx))
            before_val = fwd_val_reg;
        else if (rd_live_reg)
            before_val = rd_data_reg;
        else
            before_val = '0;

        after_val = req.minus ? (before_val - CNT_W'(1)) : (before_val + CNT_W'(1));

        nz_upd = nz_reg;
        if (req.counted)
        begin
            if (before_val == '0)
                nz_upd = nz_reg + NZ_W'(1);
            else if (after_val == '0)
                nz_upd = nz_reg - NZ_W'(1);
        end

        do_write = req.valid && req.counted && !req.last;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
        if (do_write)
            mem[req.idx] <= after_val;
        fwd_idx_reg <= req.idx;
        fwd_val_reg <= after_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
            nz_reg      <= '0;
            fwd_wr_reg  <= 1'b0;
            fwd_clr_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_live_reg <= live_reg[rd_idx];
            fwd_wr_reg  <= do_write;
            fwd_clr_reg <= req.valid && req.last;
            if (req.valid)
            begin
                if (req.last)
                begin
                    live_reg <= '0;
                    nz_reg   <= '0;
                end
                else
                begin
                    nz_reg <= nz_upd;
                    if (req.counted)
                        live_reg[req.idx] <= 1'b1;
                end
            end
        end
    end

    assign res_valid = req.valid && req.last;
    assign res       = '{too_long: req.too_long, is_anagram: (nz_upd == '0)};

endmodule

// File: rtl/apc_out_fifo.sv
// Small result queue between the histogram stage and the output channel.
// Depends on apc_pkg.
module apc_out_fifo
    import apc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  apc_res_t          push_data,
    input  logic              pop_ready,
    output logic              pop_valid,
    output apc_res_t          pop_data,
    output logic [OCNT_W-1:0] count
);

    apc_res_t          buf_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0] count_reg;
    logic              pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = buf_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + OCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - OCNT_W'(1);
        end
    end

endmodule
